// ----- hw/rtl/encoder_speed_pid_core_macros.svh -----
// Assertion helpers shared by the speed PID blocks.
// Both expect clk and arst_n in scope.
`ifndef ENCODER_SPEED_PID_CORE_MACROS_SVH
`define ENCODER_SPEED_PID_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define ESPID_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("espid check failed");
`define ESPID_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("espid check failed");
`else
`define ESPID_ASSERT_NOW(lbl, ante, cons)
`define ESPID_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ----- hw/rtl/espid_pkg.sv -----
package espid_pkg;

	localparam int unsigned CfgIdxW = 8;

	localparam logic [CfgIdxW-1:0] REG_PROP_GAIN      = 8'd0;
	localparam logic [CfgIdxW-1:0] REG_INTEGRAL_GAIN  = 8'd1;
	localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN     = 8'd2;
	localparam logic [CfgIdxW-1:0] REG_THROTTLE_SCALE = 8'd3;

	// 250.0 in Q16.16, and 0x79 counts per step
	localparam logic signed [31:0] PROP_GAIN_RST      = 32'sd16384000;
	localparam logic [15:0]        THROTTLE_SCALE_RST = 16'd121;

	// per-sample integral increment bound, 2^40
	localparam logic signed [65:0] ITERM_LIM = 66'sd1099511627776;
	// integral accumulator bound, 2047.0 in Q16.16
	localparam logic signed [42:0] INT_LIM   = 43'sd134152192;
	// drive bounds on the floored sum
	localparam logic signed [49:0] DRIVE_HI  = 50'sd2047;
	localparam logic signed [49:0] DRIVE_LO  = -50'sd2047;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_SP   = 7'b0000010,
		ST_P    = 7'b0000100,
		ST_I    = 7'b0001000,
		ST_D    = 7'b0010000,
		ST_FIN  = 7'b0100000,
		ST_OUT  = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {
		MUL_SP = 2'd0,
		MUL_P  = 2'd1,
		MUL_I  = 2'd2,
		MUL_D  = 2'd3
	} mul_sel_t;

	typedef struct packed {
		mul_sel_t mul_sel;
		logic     mul_en;
		logic     ld_err;
		logic     ld_pterm;
		logic     upd_int;
		logic     add_d;
		logic     ld_out;
	} ctrl_t;

endpackage

// ----- hw/rtl/espid_mult.sv -----
module espid_mult (
	input  logic               clk,
	input  logic               en,
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p_q
);
	import espid_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= a * b;
		end
	end

endmodule

// ----- hw/rtl/espid_ctrl.sv -----
`include "encoder_speed_pid_core_macros.svh"

module espid_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             out_free,
	output logic             in_ready,
	output espid_pkg::ctrl_t ctrl
);
	import espid_pkg::*;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		ctrl    = '{mul_sel: MUL_SP, default: 1'b0};
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) state_d = ST_SP;
			end
			ST_SP: begin
				ctrl.mul_sel = MUL_SP;
				ctrl.mul_en  = 1'b1;
				state_d      = ST_P;
			end
			ST_P: begin
				ctrl.mul_sel = MUL_P;
				ctrl.mul_en  = 1'b1;
				ctrl.ld_err  = 1'b1;
				state_d      = ST_I;
			end
			ST_I: begin
				ctrl.mul_sel  = MUL_I;
				ctrl.mul_en   = 1'b1;
				ctrl.ld_pterm = 1'b1;
				state_d       = ST_D;
			end
			ST_D: begin
				ctrl.mul_sel = MUL_D;
				ctrl.mul_en  = 1'b1;
				ctrl.upd_int = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				ctrl.add_d = 1'b1;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					ctrl.ld_out = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign in_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	`ESPID_ASSERT_NEXT(a_sp_then_p, state_q == ST_SP, state_q == ST_P)
	`ESPID_ASSERT_NEXT(a_fin_then_out, state_q == ST_FIN, state_q == ST_OUT)
	`ESPID_ASSERT_NEXT(a_out_to_idle, ctrl.ld_out, state_q == ST_IDLE)

endmodule

// ----- hw/rtl/encoder_speed_pid_core.sv -----
// Channel  | Handshake            | Payload
// ---------+----------------------+-------------------------------------
// input    | in_valid / in_ready  | throttle[31:0], encoder_count[31:0]
// result   | out_valid / out_ready| drive[11:0]
// config   | cfg_valid / cfg_ready| cfg_index[7:0], cfg_data[31:0]
//
// From input transfer to result valid: four products through the
// one shared 33x33 multiplier (setpoint, P, I, D), then two adder passes.
// One item in flight; in_ready is low until the result loads.
// A waiting result sits in the output register and stalls only the last step.
// Async reset clears gains to defaults and prev count, prev speed and integral to 0.
// cfg_ready is always high; unknown indexes are dropped.
`include "encoder_speed_pid_core_macros.svh"

module encoder_speed_pid_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [31:0]             throttle,
	input  logic signed [31:0]             encoder_count,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [11:0]             drive,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [espid_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [31:0]                    cfg_data
);
	import espid_pkg::*;

	ctrl_t ctrl;
	logic  in_fire, out_free;

	logic signed [31:0] prop_gain_q, integral_gain_q, deriv_gain_q;
	logic [15:0]        throttle_scale_q;

	logic signed [31:0] throttle_q, speed_q, prev_speed_q;
	logic [31:0]        prev_count_q;
	logic signed [32:0] err_q;
	logic signed [65:0] sum_q;
	logic signed [27:0] integral_q;
	logic signed [11:0] drive_q;
	logic               out_valid_q;

	logic signed [32:0] mul_a, mul_b, err_c, dspd_c;
	logic signed [65:0] prod_q, total_c;
	logic signed [41:0] iterm_c;
	logic signed [42:0] int_sum_c;
	logic signed [27:0] int_next_c;
	logic signed [49:0] floor_c;
	logic signed [11:0] drive_c;

	assign in_fire   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign drive     = drive_q;

	espid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.out_free (out_free),
		.in_ready (in_ready),
		.ctrl     (ctrl)
	);

	// setpoint is the floored product, bits 47:16
	assign err_c  = {prod_q[47], prod_q[47:16]} - {speed_q[31], speed_q};
	assign dspd_c = {prev_speed_q[31], prev_speed_q} - {speed_q[31], speed_q};

	always_comb begin
		case (ctrl.mul_sel)
			MUL_SP: begin
				mul_a = {throttle_q[31], throttle_q};
				mul_b = {17'd0, throttle_scale_q};
			end
			MUL_P: begin
				mul_a = {prop_gain_q[31], prop_gain_q};
				mul_b = err_c;
			end
			MUL_I: begin
				mul_a = {integral_gain_q[31], integral_gain_q};
				mul_b = err_q;
			end
			default: begin
				mul_a = {deriv_gain_q[31], deriv_gain_q};
				mul_b = dspd_c;
			end
		endcase
	end

	espid_mult u_mult (
		.clk (clk),
		.en  (ctrl.mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod_q)
	);

	// integral update: bound the increment, then the accumulator
	always_comb begin
		if (prod_q > ITERM_LIM) begin
			iterm_c = ITERM_LIM[41:0];
		end else if (prod_q < -ITERM_LIM) begin
			iterm_c = -ITERM_LIM[41:0];
		end else begin
			iterm_c = prod_q[41:0];
		end
		int_sum_c = {{15{integral_q[27]}}, integral_q} + {iterm_c[41], iterm_c};
		if (int_sum_c > INT_LIM) begin
			int_next_c = INT_LIM[27:0];
		end else if (int_sum_c < -INT_LIM) begin
			int_next_c = -INT_LIM[27:0];
		end else begin
			int_next_c = int_sum_c[27:0];
		end
	end

	assign total_c = sum_q + {{38{integral_q[27]}}, integral_q};
	assign floor_c = total_c[65:16];

	always_comb begin
		if (floor_c > DRIVE_HI) begin
			drive_c = DRIVE_HI[11:0];
		end else if (floor_c < DRIVE_LO) begin
			drive_c = DRIVE_LO[11:0];
		end else begin
			drive_c = floor_c[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prop_gain_q      <= PROP_GAIN_RST;
			integral_gain_q  <= '0;
			deriv_gain_q     <= '0;
			throttle_scale_q <= THROTTLE_SCALE_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PROP_GAIN:      prop_gain_q      <= cfg_data;
				REG_INTEGRAL_GAIN:  integral_gain_q  <= cfg_data;
				REG_DERIV_GAIN:     deriv_gain_q     <= cfg_data;
				REG_THROTTLE_SCALE: throttle_scale_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_count_q <= '0;
			prev_speed_q <= '0;
			integral_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_fire) prev_count_q <= encoder_count;
			if (ctrl.upd_int) begin
				integral_q   <= int_next_c;
				prev_speed_q <= speed_q;
			end
			if (ctrl.ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			throttle_q <= throttle;
			speed_q    <= encoder_count - prev_count_q;
		end
		if (ctrl.ld_err)   err_q   <= err_c;
		if (ctrl.ld_pterm) sum_q   <= prod_q;
		if (ctrl.add_d)    sum_q   <= sum_q + prod_q;
		if (ctrl.ld_out)   drive_q <= drive_c;
	end

	`ESPID_ASSERT_NEXT(a_busy_after_in, in_fire, !in_ready)
	`ESPID_ASSERT_NOW(a_int_bound, 1'b1,
		($signed({{15{integral_q[27]}}, integral_q}) <= INT_LIM) &&
		($signed({{15{integral_q[27]}}, integral_q}) >= -INT_LIM))
	`ESPID_ASSERT_NOW(a_drive_bound, out_valid_q,
		(drive_q <= $signed(DRIVE_HI[11:0])) && (drive_q >= $signed(DRIVE_LO[11:0])))

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
	import espid_pkg::*;

	typedef logic signed [95:0] wide_t;

	localparam wide_t ITERM_BOUND = 96'sd1099511627776;
	localparam wide_t INT_BOUND   = 96'sd134152192;
	localparam wide_t DRIVE_BOUND = 96'sd2047;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int RANDOM_ITEMS   = 1900;

	localparam logic [CfgIdxW-1:0] REG_FIRST_UNMAPPED = REG_THROTTLE_SCALE + CfgIdxW'(1);
	localparam logic [CfgIdxW-1:0] REG_LAST_UNMAPPED  = 8'hff;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [31:0]        throttle = '0;
	logic signed [31:0]        encoder_count = '0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic signed [11:0]        drive;
	logic                      cfg_valid = 1'b0;
	logic                      cfg_ready;
	logic [CfgIdxW-1:0]        cfg_index = '0;
	logic [31:0]               cfg_data = '0;

	encoder_speed_pid_core DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.throttle      (throttle),
		.encoder_count (encoder_count),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.drive         (drive),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial forever #5 clk = ~clk;

	// controller state as the testbench sees it
	wide_t              kp, ki, kd;
	logic [15:0]        tscale;
	logic [31:0]        last_count;
	logic signed [31:0] last_speed;
	wide_t              int_acc;

	logic signed [11:0] pending_drive[$];
	logic signed [11:0] want_drive;
	int                 err_count = 0;
	int                 gap_pct = 30;
	int                 stall_pct = 30;
	int                 stall_left = 0;
	int                 stall_pick;
	int                 idle_cycles = 0;

	// trajectory of a well-behaved motor for the random items
	logic [31:0]        traj_pos = '0;
	int                 traj_vel = 0;
	logic signed [31:0] traj_thr = '0;

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		err_count++;
	endtask

	function automatic wide_t clamp_wide(input wide_t v, input wide_t lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	task automatic reset_controller();
		kp = PROP_GAIN_RST;
		ki = '0;
		kd = '0;
		tscale = THROTTLE_SCALE_RST;
		last_count = '0;
		last_speed = '0;
		int_acc = '0;
	endtask

	task automatic update_gain(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		case (idx)
			REG_PROP_GAIN: begin
				kp = $signed(val);
			end
			REG_INTEGRAL_GAIN: begin
				ki = $signed(val);
			end
			REG_DERIV_GAIN: begin
				kd = $signed(val);
			end
			REG_THROTTLE_SCALE: begin
				tscale = val[15:0];
			end
			default: ;
		endcase
	endtask

	// all products and sums are exact at 96 bits; only speed wraps
	function automatic logic signed [11:0] predict_drive(input logic signed [31:0] thr,
			input logic [31:0] cnt);
		logic signed [31:0] speed32;
		wide_t thr_w, scale_w, spd, last_w, setpt, err, pt, it, dt, total;
		speed32 = cnt - last_count;
		thr_w = thr;
		scale_w = tscale;
		spd = speed32;
		last_w = last_speed;
		setpt = (thr_w * scale_w) >>> 16;
		err = setpt - spd;
		pt = kp * err;
		it = clamp_wide(ki * err, ITERM_BOUND);
		dt = kd * (last_w - spd);
		int_acc = clamp_wide(int_acc + it, INT_BOUND);
		total = pt + dt + int_acc;
		last_count = cnt;
		last_speed = speed32;
		total = clamp_wide(total >>> 16, DRIVE_BOUND);
		return total[11:0];
	endfunction

	function automatic int idle_len(input int pct);
		int r;
		if ($urandom_range(99) >= pct)
			return 0;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(3, 1);
		if (r < 95)
			return $urandom_range(12, 4);
		return $urandom_range(40, 20);
	endfunction

	function automatic logic signed [31:0] rand_signed(input int unsigned mag);
		return int'($urandom_range(2 * mag, 0)) - int'(mag);
	endfunction

	// valid is left high after a transfer when no gap follows
	task automatic send_item(input logic signed [31:0] thr, input logic [31:0] cnt);
		int gap;
		throttle <= thr;
		encoder_count <= cnt;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pending_drive.push_back(predict_drive(thr, cnt));
		gap = idle_len(gap_pct);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_drive.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		update_gain(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_defaults_first_step();
		send_item(32'sd0, 32'd1000);	// first step: speed is the whole count
		send_item(32'sd0, 32'd1000);
		send_item(32'sd1, 32'd1000);	// setpoint floors to zero
		send_item(-32'sd1, 32'd1000);	// setpoint floors to -1
		send_item(32'sh7fffffff, 32'd1000);
		send_item(32'sh80000000, 32'h7fffffff);
		send_item(32'sd0, 32'h80000000);	// count wraps, speed +1
		send_item(32'sd0, 32'd0);
		drain();
	endtask

	task automatic test_register_extremes();
		write_reg(REG_PROP_GAIN, 32'h7fffffff);
		write_reg(REG_INTEGRAL_GAIN, 32'h7fffffff);
		write_reg(REG_DERIV_GAIN, 32'h80000000);
		write_reg(REG_THROTTLE_SCALE, 32'hffffffff);
		send_item(32'sh7fffffff, 32'h80000000);
		send_item(32'sh80000000, 32'h7fffffff);
		send_item(32'sh80000000, 32'h80000000);
		drain();
		write_reg(REG_PROP_GAIN, 32'h80000000);
		write_reg(REG_INTEGRAL_GAIN, 32'h80000000);
		write_reg(REG_DERIV_GAIN, 32'h7fffffff);
		write_reg(REG_THROTTLE_SCALE, 32'h00000000);
		send_item(32'sh7fffffff, 32'd0);
		send_item(32'sd0, 32'h7fffffff);
		send_item(-32'sd1, 32'h80000000);
		drain();
	endtask

	task automatic test_integral_and_derivative();
		// constant error of 1000 winds the integral into its bound
		write_reg(REG_PROP_GAIN, 32'd0);
		write_reg(REG_INTEGRAL_GAIN, 32'h00010000);
		write_reg(REG_DERIV_GAIN, 32'd0);
		write_reg(REG_THROTTLE_SCALE, 32'd1);
		send_item(32'sd1000 <<< 16, 32'd5000);
		repeat (3) send_item(32'sd1000 <<< 16, 32'd5000);
		send_item(-(32'sd1000 <<< 16), 32'd5000);
		drain();
		// derivative on measurement: only a change of speed moves the drive
		write_reg(REG_INTEGRAL_GAIN, 32'd0);
		write_reg(REG_DERIV_GAIN, 32'h00010000);
		send_item(32'sd0, 32'd5010);
		send_item(32'sd0, 32'd5030);
		send_item(32'sd0, 32'd5050);
		drain();
	endtask

	task automatic test_unmapped_index();
		write_reg(REG_PROP_GAIN, 32'h00010000);
		write_reg(REG_FIRST_UNMAPPED, 32'h12345678);
		write_reg(REG_LAST_UNMAPPED, 32'hffffffff);
		send_item(32'sd3 <<< 16, 32'd5050);
		send_item(32'sd0, 32'd5100);
		drain();
	endtask

	function automatic logic [31:0] pick_gain(input logic [CfgIdxW-1:0] idx, input int style);
		if (style == 9)
			return $urandom;
		if (style >= 7) begin
			if (idx == REG_THROTTLE_SCALE)
				return $urandom_range(1) ? 32'h0000ffff : 32'd0;
			case ($urandom_range(4))
				0: return 32'h7fffffff;
				1: return 32'h80000000;
				2: return 32'hffffffff;
				3: return 32'h00010000;
				default: return 32'd0;
			endcase
		end
		case (idx)
			REG_PROP_GAIN:      return rand_signed(4 << 16);
			REG_INTEGRAL_GAIN:  return rand_signed(1 << 15);
			REG_DERIV_GAIN:     return rand_signed(1 << 16);
			default:            return $urandom_range(200, 0);
		endcase
	endfunction

	task automatic randomise_gains();
		logic [CfgIdxW-1:0] idx;
		int style;
		style = $urandom_range(9);
		for (idx = REG_PROP_GAIN; idx <= REG_THROTTLE_SCALE; idx++)
			if ($urandom_range(99) < 70)
				write_reg(idx, pick_gain(idx, style));
		if ($urandom_range(9) == 0)
			write_reg(CfgIdxW'($urandom_range(REG_LAST_UNMAPPED, REG_FIRST_UNMAPPED)),
				$urandom);
	endtask

	task automatic send_random_item();
		int r;
		r = $urandom_range(99);
		if (r < 80) begin
			traj_vel = traj_vel + int'($urandom_range(40, 0)) - 20;
			if ($urandom_range(31) == 0)
				traj_vel = rand_signed(2000);
			if (traj_vel > 3000)
				traj_vel = 3000;
			if (traj_vel < -3000)
				traj_vel = -3000;
			traj_pos = traj_pos + traj_vel;
			if ($urandom_range(15) == 0)
				traj_thr = rand_signed(8 << 16);
			send_item(traj_thr, traj_pos);
		end else if (r < 90) begin
			send_item($urandom, $urandom);
		end else if (r < 95) begin
			send_item($urandom, traj_pos);
		end else begin
			send_item(traj_thr, $urandom);
		end
	endtask

	task automatic test_random_phases();
		int sent;
		int phase_len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain();
			randomise_gains();
			case ($urandom_range(3))
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 20; stall_pct = 20; end
				2: begin gap_pct = 50; stall_pct = 10; end
				default: begin gap_pct = 10; stall_pct = 60; end
			endcase
			phase_len = $urandom_range(160, 40);
			repeat (phase_len) begin
				send_random_item();
				sent++;
				// hold the sender until every drive is back
				if ($urandom_range(99) == 0)
					drain();
			end
		end
		drain();
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			stall_pick = idle_len(stall_pct);
			out_ready <= (stall_pick == 0);
			stall_left <= (stall_pick > 0) ? stall_pick - 1 : 0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_drive.size() == 0) begin
				report_mismatch($sformatf("drive %0d with no transfer pending", drive));
			end else begin
				want_drive = pending_drive.pop_front();
				if (drive !== want_drive)
					report_mismatch($sformatf("drive %0d, want %0d", drive, want_drive));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		reset_controller();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults_first_step();
		test_register_extremes();
		test_integral_and_derivative();
		test_unmapped_index();
		test_random_phases();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_drive.size() != 0)
			report_mismatch($sformatf("%0d drive values never arrived", pending_drive.size()));
		if (err_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
